### rtl/ps2mpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpd_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2mpd_pkg;

  // Configuration register indexes
  typedef enum logic {
    CFG_ENABLE     = 1'b0,
    CFG_WHEEL_MODE = 1'b1
  } cfg_idx_e;

  // Scroll direction codes
  typedef enum logic [1:0] {
    SCROLL_NONE = 2'd0,
    SCROLL_UP   = 2'd1,
    SCROLL_DOWN = 2'd2
  } scroll_e;

  // Button and delta widths, and bit positions in the first byte of a packet
  localparam int unsigned BtnW      = 3;
  localparam int unsigned SyncBit   = 3;
  localparam int unsigned XSignBit  = 4;
  localparam int unsigned YSignBit  = 5;
  localparam int unsigned XOvfBit   = 6;
  localparam int unsigned YOvfBit   = 7;
  localparam int unsigned DeltaW    = 9;

  // Packet lengths in bytes
  localparam logic [2:0] PktLenStd   = 3'd3;
  localparam logic [2:0] PktLenWheel = 3'd4;

  // A complete packet handed from the assembler to the decoder
  typedef struct packed {
    logic [7:0] head;
    logic [7:0] x_mag;
    logic [7:0] y_mag;
    scroll_e    scroll;
  } packet_t;

endpackage

### rtl/ps2_mouse_packet_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_core
// PS/2 mouse packet decoder: bytes in, button/movement/scroll items out.
// ----------------------------------------------------------------------------
// Accepts one received byte per cycle. Bytes are gathered into 3-byte packets
// (4 with wheel_mode) in a byte store; a finished packet sits in one register,
// is decoded combinationally and lands in the result register. A full result
// register stalls the input only once a second finished packet is waiting
// behind it. Packets that change nothing are dropped. Write configuration only
// while idle.
module ps2_mouse_packet_decoder_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic              cfg_data_i,
  // received bytes
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  logic [7:0]        rx_byte_i,
  // decoded items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        buttons_o,
  output logic signed [8:0] delta_x_o,
  output logic signed [8:0] delta_y_o,
  output logic [1:0]        scroll_o
);

  logic                enable_q;
  logic                wheel_mode_q;
  logic                pkt_valid;
  logic                pkt_take;
  ps2mpd_pkg::packet_t pkt;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      wheel_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (ps2mpd_pkg::cfg_idx_e'(cfg_idx_i))
        ps2mpd_pkg::CFG_ENABLE:     enable_q     <= cfg_data_i;
        ps2mpd_pkg::CFG_WHEEL_MODE: wheel_mode_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ps2mpd_assembler u_assembler (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (enable_q),
    .wheel_mode_i (wheel_mode_q),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .pkt_take_i   (pkt_take),
    .pkt_valid_o  (pkt_valid),
    .pkt_o        (pkt)
  );

  ps2mpd_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_valid_i (pkt_valid),
    .pkt_i       (pkt),
    .pkt_take_o  (pkt_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .buttons_o   (buttons_o),
    .delta_x_o   (delta_x_o),
    .delta_y_o   (delta_y_o),
    .scroll_o    (scroll_o)
  );

endmodule

### rtl/ps2mpd_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpd_assembler
// Gathers received bytes into packets and holds one finished packet.
// ----------------------------------------------------------------------------
module ps2mpd_assembler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                enable_i,
  input  logic                wheel_mode_i,
  input  logic                rx_valid_i,
  output logic                rx_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                pkt_take_i,
  output logic                pkt_valid_o,
  output ps2mpd_pkg::packet_t pkt_o
);

  logic [1:0]          byte_idx_q, byte_idx_d;
  logic [7:0]          head_q, x_q, y_q;
  logic                pkt_valid_q, pkt_valid_d;
  ps2mpd_pkg::packet_t pkt_q;
  logic                accept;
  logic                use_byte;
  logic                last_byte;
  logic [2:0]          pkt_len;
  logic [2:0]          idx_next;
  ps2mpd_pkg::scroll_e scroll;

  // Free slot, or the held packet leaves this cycle
  assign rx_ready_o = !pkt_valid_q || pkt_take_i;
  assign accept     = rx_valid_i && rx_ready_o;

  // Drop bytes while disabled, and a packet start without the sync bit
  assign use_byte = accept && enable_i &&
                    !(byte_idx_q == 2'd0 && !rx_byte_i[ps2mpd_pkg::SyncBit]);

  assign pkt_len   = wheel_mode_i ? ps2mpd_pkg::PktLenWheel : ps2mpd_pkg::PktLenStd;
  assign idx_next  = {1'b0, byte_idx_q} + 3'd1;
  assign last_byte = !(idx_next < pkt_len);
  assign byte_idx_d = !use_byte ? byte_idx_q :
                      last_byte ? 2'd0 : idx_next[1:0];

  // Scroll from the wheel byte, only in wheel mode
  always_comb begin
    scroll = ps2mpd_pkg::SCROLL_NONE;
    if (wheel_mode_i) begin
      if (rx_byte_i[7]) begin
        scroll = ps2mpd_pkg::SCROLL_UP;
      end else if (rx_byte_i != 8'd0) begin
        scroll = ps2mpd_pkg::SCROLL_DOWN;
      end
    end
  end

  assign pkt_valid_d = (use_byte && last_byte) || (pkt_valid_q && !pkt_take_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q  <= 2'd0;
      pkt_valid_q <= 1'b0;
    end else begin
      byte_idx_q  <= byte_idx_d;
      pkt_valid_q <= pkt_valid_d;
    end
  end

  // Packet byte store and finished packet register
  always_ff @(posedge clk_i) begin
    if (use_byte) begin
      case (byte_idx_q)
        2'd0:    head_q <= rx_byte_i;
        2'd1:    x_q    <= rx_byte_i;
        2'd2:    y_q    <= rx_byte_i;
        default: ;
      endcase
      if (last_byte) begin
        pkt_q.head   <= head_q;
        pkt_q.x_mag  <= x_q;
        // third byte completes a short packet directly
        pkt_q.y_mag  <= (byte_idx_q == 2'd2) ? rx_byte_i : y_q;
        pkt_q.scroll <= scroll;
      end
    end
  end

  assign pkt_valid_o = pkt_valid_q;
  assign pkt_o       = pkt_q;

  // A finished packet always starts with a synced byte
  a_head_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_q |-> pkt_q.head[ps2mpd_pkg::SyncBit])
    else $error("packet head without sync bit");

  // A held packet stays until the decoder takes it
  a_pkt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_q && !pkt_take_i |=> pkt_valid_q && $stable(pkt_q))
    else $error("pending packet lost or changed");

endmodule

### rtl/ps2mpd_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpd_decoder
// Decodes a finished packet, filters unchanged events, holds the result.
// ----------------------------------------------------------------------------
module ps2mpd_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pkt_valid_i,
  input  ps2mpd_pkg::packet_t             pkt_i,
  output logic                            pkt_take_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ps2mpd_pkg::BtnW-1:0]     buttons_o,
  output logic signed [ps2mpd_pkg::DeltaW-1:0] delta_x_o,
  output logic signed [ps2mpd_pkg::DeltaW-1:0] delta_y_o,
  output logic [1:0]                      scroll_o
);

  logic                              out_valid_q, out_valid_d;
  logic [ps2mpd_pkg::BtnW-1:0]       last_btn_q;
  logic [ps2mpd_pkg::BtnW-1:0]       btn_q;
  logic [ps2mpd_pkg::DeltaW-1:0]     dx_q, dy_q;
  ps2mpd_pkg::scroll_e               scroll_q;
  logic [ps2mpd_pkg::BtnW-1:0]       btn;
  logic [ps2mpd_pkg::DeltaW-1:0]     dx, dy;
  logic                              emit;
  logic                              load;

  // Sign extension; a zero magnitude stays zero, overflow forces zero
  function automatic logic [ps2mpd_pkg::DeltaW-1:0] ext_delta(
    input logic [7:0] mag,
    input logic       sign,
    input logic       ovf
  );
    logic [ps2mpd_pkg::DeltaW-1:0] v;
    v = {sign && (mag != 8'd0), mag};
    if (ovf) begin
      v = '0;
    end
    return v;
  endfunction

  assign btn = pkt_i.head[ps2mpd_pkg::BtnW-1:0];
  assign dx  = ext_delta(pkt_i.x_mag, pkt_i.head[ps2mpd_pkg::XSignBit],
                         pkt_i.head[ps2mpd_pkg::XOvfBit]);
  assign dy  = ext_delta(pkt_i.y_mag, pkt_i.head[ps2mpd_pkg::YSignBit],
                         pkt_i.head[ps2mpd_pkg::YOvfBit]);

  // Report only when something changed or moved
  assign emit = (btn != last_btn_q) || (dx != '0) || (dy != '0) ||
                (pkt_i.scroll != ps2mpd_pkg::SCROLL_NONE);

  // A packet that yields nothing is always taken
  assign pkt_take_o  = !out_valid_q || out_ready_i || !emit;
  assign load        = pkt_valid_i && emit && pkt_take_o;
  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_btn_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        last_btn_q <= btn;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      btn_q    <= btn;
      dx_q     <= dx;
      dy_q     <= dy;
      scroll_q <= pkt_i.scroll;
    end
  end

  assign out_valid_o = out_valid_q;
  assign buttons_o   = btn_q;
  assign delta_x_o   = dx_q;
  assign delta_y_o   = dy_q;
  assign scroll_o    = scroll_q;

  // Button history tracks the last reported item
  a_last_btn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> last_btn_q == btn_q)
    else $error("button history out of step with result");

  // A negative delta never has a zero magnitude
  a_dx_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && dx_q[ps2mpd_pkg::DeltaW-1] |-> dx_q[7:0] != 8'd0)
    else $error("negative zero on delta_x");

  a_dy_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && dy_q[ps2mpd_pkg::DeltaW-1] |-> dy_q[7:0] != 8'd0)
    else $error("negative zero on delta_y");

endmodule
